// ===== hw/rtl/dsrm_pkg.sv =====
package dsrm_pkg;

   localparam int MAX_TOKENS = 32;
   localparam int POS_COUNT = MAX_TOKENS + 1;
   localparam int COUNT_WIDTH = 6;
   localparam int INDEX_WIDTH = 5;
   localparam int CHAR_WIDTH = 8;
   localparam int KIND_WIDTH = 2;

   localparam logic [CHAR_WIDTH-1:0] CH_DOT = 8'd46;
   localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 6'd1;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_LOAD = 2'd0,
      KIND_TEXT = 2'd1,
      KIND_END  = 2'd2
   } kind_type;

   typedef logic [CHAR_WIDTH-1:0] char_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [POS_COUNT-1:0] pos_set_type;

   // command from the request stage into the nfa core
   typedef struct packed {
      logic     step;
      logic     finish;
      char_type text_char;
   } nfa_cmd_type;

endpackage

// ===== hw/rtl/dsrm_if.sv =====
interface dsrm_req_if;
   logic                             valid;
   logic                             ready;
   logic [dsrm_pkg::KIND_WIDTH-1:0]  kind;
   logic [dsrm_pkg::INDEX_WIDTH-1:0] token_index;
   logic [dsrm_pkg::CHAR_WIDTH-1:0]  token_char;
   logic                             token_starred;
   logic [dsrm_pkg::CHAR_WIDTH-1:0]  text_char;

   modport source (output valid, kind, token_index, token_char, token_starred, text_char,
                   input ready);
   modport sink (input valid, kind, token_index, token_char, token_starred, text_char,
                 output ready);
endinterface

interface dsrm_rsp_if;
   logic valid;
   logic ready;
   logic matched;

   modport source (output valid, matched, input ready);
   modport sink (input valid, matched, output ready);
endinterface

interface dsrm_csr_if;
   logic                             valid;
   logic                             ready;
   logic [dsrm_pkg::COUNT_WIDTH-1:0] pattern_tokens;

   modport source (output valid, pattern_tokens, input ready);
   modport sink (input valid, pattern_tokens, output ready);
endinterface

// ===== hw/rtl/dsrm_token_table.sv =====
module dsrm_token_table (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [dsrm_pkg::INDEX_WIDTH-1:0] wr_index,
   input  dsrm_pkg::char_type               wr_char,
   input  logic                             wr_starred,
   output dsrm_pkg::char_type               token_bytes [dsrm_pkg::MAX_TOKENS],
   output logic [dsrm_pkg::MAX_TOKENS-1:0]  token_stars
);
   import dsrm_pkg::*;

   char_type                bytes_ff [MAX_TOKENS];
   logic [MAX_TOKENS-1:0]   stars_ff;
   logic                    slot_ok;

   // loads beyond the table are dropped
   assign slot_ok = {1'b0, wr_index} < (INDEX_WIDTH + 1)'(MAX_TOKENS);

   always_ff @(posedge clock) begin
      if (reset) begin
         // star flags start known so the closure carry chain never sees unknowns
         stars_ff <= '0;
      end else begin
         for (int i = 0; i < MAX_TOKENS; i++) begin
            if (wr_en && slot_ok && ({1'b0, wr_index} == (INDEX_WIDTH + 1)'(i))) begin
               bytes_ff[i] <= wr_char;
               stars_ff[i] <= wr_starred;
            end
         end
      end
   end

   assign token_bytes = bytes_ff;
   assign token_stars = stars_ff;

endmodule

// ===== hw/rtl/dsrm_nfa_core.sv =====
module dsrm_nfa_core (
   input  logic                            clock,
   input  logic                            reset,
   input  dsrm_pkg::nfa_cmd_type           cmd,
   input  dsrm_pkg::count_type             token_count,
   input  dsrm_pkg::char_type              token_bytes [dsrm_pkg::MAX_TOKENS],
   input  logic [dsrm_pkg::MAX_TOKENS-1:0] token_stars,
   output logic                            match_now
);
   import dsrm_pkg::*;

   pos_set_type           live_ff;
   pos_set_type           live_in;
   count_type             n;
   logic [MAX_TOKENS-1:0] in_use;
   pos_set_type           stars_m;
   pos_set_type           gen;
   pos_set_type           sum;
   pos_set_type           closed;
   logic [MAX_TOKENS-1:0] hit;
   pos_set_type           next_set;

   assign n = (token_count > COUNT_WIDTH'(MAX_TOKENS)) ? COUNT_WIDTH'(MAX_TOKENS) : token_count;

   always_comb begin
      for (int i = 0; i < MAX_TOKENS; i++) begin
         in_use[i] = COUNT_WIDTH'(i) < n;
      end
   end

   // epsilon closure as a carry chain: live bits generate, starred tokens propagate
   assign stars_m = {1'b0, token_stars & in_use};
   assign gen     = live_ff & stars_m;
   assign sum     = stars_m + gen;
   assign closed  = live_ff | (sum ^ stars_m ^ gen);

   always_comb begin
      for (int i = 0; i < MAX_TOKENS; i++) begin
         hit[i] = closed[i] && in_use[i]
                  && ((token_bytes[i] == CH_DOT) || (token_bytes[i] == cmd.text_char));
      end
   end

   // starred hits stay in place, plain hits advance one position
   assign next_set = {1'b0, hit & token_stars} | {hit & ~token_stars, 1'b0};

   assign match_now = closed[n];

   always_comb begin
      live_in = live_ff;
      if (cmd.finish) begin
         live_in = POS_COUNT'(1);
      end else if (cmd.step) begin
         live_in = next_set;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= POS_COUNT'(1);
      end else begin
         live_ff <= live_in;
      end
   end

endmodule

// ===== hw/rtl/dot_star_regex_matcher_unit.sv =====
// channel   direction  fields                                               role
// req_if    in         kind, token_index, token_char, token_starred,        pattern load,
//                      text_char                                            text, end of text
// rsp_if    out        matched                                              one per end of text
// csr_if    in         pattern_tokens                                       token count
//
// one transaction per cycle sustained while no end-of-text request waits on a full output
// register; a request sits in the input register, the nfa update runs while it sits there,
// and a result is registered in the output register.
// the closure is one 33-bit carry chain, so a text byte never iterates.
// reset (synchronous) clears valids and star flags, sets token count to 1 and
// the live set to position 0.
// a full output register holds an end-of-text request in the input register,
// and while it waits req_if takes nothing; load and text requests never wait.
module dot_star_regex_matcher_unit (
   input logic       clock,
   input logic       reset,
   dsrm_req_if.sink  req_if,
   dsrm_rsp_if.source rsp_if,
   dsrm_csr_if.sink  csr_if
);
   import dsrm_pkg::*;

   logic                   in_valid_ff;
   logic [KIND_WIDTH-1:0]  kind_ff;
   logic [INDEX_WIDTH-1:0] token_index_ff;
   char_type               token_char_ff;
   logic                   token_starred_ff;
   char_type               text_char_ff;

   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic                   matched_ff;

   count_type              count_ff;

   logic                   is_load;
   logic                   is_text;
   logic                   is_end;
   logic                   out_free;
   logic                   advance;
   logic                   match_now;
   nfa_cmd_type            cmd;
   char_type               token_bytes [MAX_TOKENS];
   logic [MAX_TOKENS-1:0]  token_stars;

   always_comb begin
      is_load = 1'b0;
      is_text = 1'b0;
      is_end  = 1'b0;
      case (kind_type'(kind_ff))
         KIND_LOAD: is_load = 1'b1;
         KIND_TEXT: is_text = 1'b1;
         KIND_END:  is_end  = 1'b1;
         default:   ;
      endcase
   end

   assign out_free = !out_valid_ff || rsp_if.ready;
   // only an end-of-text transaction needs room in the output register
   assign advance  = in_valid_ff && (!is_end || out_free);
   assign req_if.ready = !in_valid_ff || advance;
   assign csr_if.ready = 1'b1;

   assign cmd.step      = advance && is_text;
   assign cmd.finish    = advance && is_end;
   assign cmd.text_char = text_char_ff;

   dsrm_token_table u_table (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (advance && is_load),
      .wr_index    (token_index_ff),
      .wr_char     (token_char_ff),
      .wr_starred  (token_starred_ff),
      .token_bytes (token_bytes),
      .token_stars (token_stars)
   );

   dsrm_nfa_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .token_count (count_ff),
      .token_bytes (token_bytes),
      .token_stars (token_stars),
      .match_now   (match_now)
   );

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_if.ready;
      if (cmd.finish) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= COUNT_RESET;
      end else begin
         if (req_if.ready) begin
            in_valid_ff <= req_if.valid;
         end
         out_valid_ff <= out_valid_in;
         if (csr_if.valid) begin
            count_ff <= csr_if.pattern_tokens;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         kind_ff          <= req_if.kind;
         token_index_ff   <= req_if.token_index;
         token_char_ff    <= req_if.token_char;
         token_starred_ff <= req_if.token_starred;
         text_char_ff     <= req_if.text_char;
      end
      if (cmd.finish) begin
         matched_ff <= match_now;
      end
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.matched = matched_ff;

endmodule

// ===== tb/dot_star_regex_matcher_unit_tb.sv =====
`timescale 1ns / 100ps

module dot_star_regex_matcher_unit_tb;
   import dsrm_pkg::*;

   localparam logic [KIND_WIDTH-1:0] KIND_IGNORED = 2'd3;
   localparam char_type CH_A = 8'd97;
   localparam char_type CH_B = 8'd98;
   localparam char_type CH_X = 8'd120;
   localparam char_type CH_Z = 8'd122;
   localparam int RANDOM_ITEMS = 450;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES = 4;
   localparam int LONG_HOLD_CYCLES = 40;
   localparam int QUIET_LIMIT = 2000;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]  kind;
      logic [INDEX_WIDTH-1:0] slot;
      char_type               tok;
      logic                   star;
      char_type               txt;
   } matcher_req_type;

   localparam int REQ_BITS = $bits(matcher_req_type);

   typedef enum logic {ROW_ITEM, ROW_COUNT} row_op_type;

   typedef struct packed {
      row_op_type             op;
      count_type              count_val;
      logic [KIND_WIDTH-1:0]  kind;
      logic [INDEX_WIDTH-1:0] slot;
      char_type               tok;
      logic                   star;
      char_type               txt;
      logic                   known;
      logic                   known_match;
   } probe_row_type;

   localparam int PROBE_ROWS = 26;

   probe_row_type probe_table [PROBE_ROWS] = '{
      '{ROW_ITEM,  6'd0,  KIND_LOAD,    5'd0,  CH_A,    1'b0, 8'd0,    1'b0, 1'b0},
      '{ROW_ITEM,  6'd0,  KIND_END,     5'd0,  8'd0,    1'b0, 8'd0,    1'b1, 1'b0},
      '{ROW_ITEM,  6'd0,  KIND_TEXT,    5'd0,  8'd0,    1'b0, CH_A,    1'b0, 1'b0},
      '{ROW_ITEM,  6'd0,  KIND_END,     5'd0,  8'd0,    1'b0, 8'd0,    1'b1, 1'b1},
      '{ROW_ITEM,  6'd0,  KIND_TEXT,    5'd0,  8'd0,    1'b0, CH_B,    1'b0, 1'b0},
      '{ROW_ITEM,  6'd0,  KIND_END,     5'd0,  8'd0,    1'b0, 8'd0,    1'b1, 1'b0},
      // unknown kind that would turn slot 0 into b* if taken as a load
      '{ROW_ITEM,  6'd0,  KIND_IGNORED, 5'd0,  CH_B,    1'b1, CH_A,    1'b0, 1'b0},
      '{ROW_ITEM,  6'd0,  KIND_TEXT,    5'd0,  8'd0,    1'b0, CH_A,    1'b0, 1'b0},
      '{ROW_ITEM,  6'd0,  KIND_END,     5'd0,  8'd0,    1'b0, 8'd0,    1'b1, 1'b1},
      // empty pattern
      '{ROW_COUNT, 6'd0,  KIND_LOAD,    5'd0,  8'd0,    1'b0, 8'd0,    1'b0, 1'b0},
      '{ROW_ITEM,  6'd0,  KIND_END,     5'd0,  8'd0,    1'b0, 8'd0,    1'b1, 1'b1},
      '{ROW_ITEM,  6'd0,  KIND_TEXT,    5'd0,  8'd0,    1'b0, 8'd0,    1'b0, 1'b0},
      '{ROW_ITEM,  6'd0,  KIND_END,     5'd0,  8'd0,    1'b0, 8'd0,    1'b1, 1'b0},
      // oversized count acts as full table
      '{ROW_COUNT, 6'd63, KIND_LOAD,    5'd0,  8'd0,    1'b0, 8'd0,    1'b0, 1'b0},
      '{ROW_ITEM,  6'd0,  KIND_LOAD,    5'd31, 8'hFF,   1'b1, 8'd0,    1'b0, 1'b0},
      '{ROW_ITEM,  6'd0,  KIND_LOAD,    5'd0,  CH_X,    1'b0, 8'd0,    1'b0, 1'b0},
      '{ROW_ITEM,  6'd0,  KIND_TEXT,    5'd0,  8'd0,    1'b0, 8'hFF,   1'b0, 1'b0},
      '{ROW_ITEM,  6'd0,  KIND_END,     5'd0,  8'd0,    1'b0, 8'd0,    1'b1, 1'b0},
      // .* then a zero byte token
      '{ROW_COUNT, 6'd2,  KIND_LOAD,    5'd0,  8'd0,    1'b0, 8'd0,    1'b0, 1'b0},
      '{ROW_ITEM,  6'd0,  KIND_LOAD,    5'd0,  CH_DOT,  1'b1, 8'd0,    1'b0, 1'b0},
      '{ROW_ITEM,  6'd0,  KIND_LOAD,    5'd1,  8'd0,    1'b0, 8'd0,    1'b0, 1'b0},
      '{ROW_ITEM,  6'd0,  KIND_TEXT,    5'd0,  8'd0,    1'b0, 8'd0,    1'b0, 1'b0},
      '{ROW_ITEM,  6'd0,  KIND_END,     5'd0,  8'd0,    1'b0, 8'd0,    1'b1, 1'b1},
      '{ROW_ITEM,  6'd0,  KIND_TEXT,    5'd0,  8'd0,    1'b0, CH_Z,    1'b0, 1'b0},
      '{ROW_ITEM,  6'd0,  KIND_END,     5'd0,  8'd0,    1'b0, 8'd0,    1'b0, 1'b0},
      // left open, the next count write lands mid-text
      '{ROW_ITEM,  6'd0,  KIND_TEXT,    5'd0,  8'd0,    1'b0, CH_Z,    1'b0, 1'b0}
   };

   logic clock;
   logic reset;

   dsrm_req_if req_if ();
   dsrm_rsp_if rsp_if ();
   dsrm_csr_if csr_if ();

   dot_star_regex_matcher_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // matcher state as seen by the predictor
   char_type    pat_char [MAX_TOKENS];
   logic        pat_star [MAX_TOKENS];
   pos_set_type live_set = pos_set_type'(1);
   count_type   count_shadow = COUNT_RESET;

   logic expected_matches [$];
   int   fails = 0;
   int   items_sent = 0;
   int   source_idle_pct = 0;
   int   sink_idle_pct = 0;
   int   hold_requests = 0;
   int   quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic pos_set_type close_stars(pos_set_type s, int n);
      pos_set_type c;
      c = '0;
      for (int i = 0; i <= n; i++) c[i] = s[i];
      for (int i = 0; i < n; i++)
         if (c[i] && pat_star[i]) c[i+1] = 1'b1;
      return c;
   endfunction

   // returns 1 when the transaction produces a match result
   function automatic bit advance_nfa(matcher_req_type r, output logic matched);
      int n;
      pos_set_type cl;
      pos_set_type nx;
      n = (count_shadow > MAX_TOKENS) ? MAX_TOKENS : int'(count_shadow);
      matched = 1'b0;
      advance_nfa = 1'b0;
      case (r.kind)
         KIND_LOAD: begin
            pat_char[r.slot] = r.tok;
            pat_star[r.slot] = r.star;
         end
         KIND_TEXT: begin
            cl = close_stars(live_set, n);
            nx = '0;
            for (int i = 0; i < n; i++) begin
               if (cl[i] && (pat_char[i] == CH_DOT || pat_char[i] == r.txt)) begin
                  if (pat_star[i]) nx[i] = 1'b1;
                  else nx[i+1] = 1'b1;
               end
            end
            live_set = nx;
         end
         KIND_END: begin
            cl = close_stars(live_set, n);
            matched = cl[n];
            live_set = pos_set_type'(1);
            advance_nfa = 1'b1;
         end
         default: ;
      endcase
   endfunction

   function automatic char_type pattern_char();
      case ($urandom_range(0, 9))
         0, 1, 2: return CH_A;
         3, 4:    return CH_B;
         5, 6:    return CH_DOT;
         7:       return '0;
         default: return char_type'($urandom);
      endcase
   endfunction

   function automatic matcher_req_type random_req(logic [KIND_WIDTH-1:0] kind);
      matcher_req_type r;
      r = matcher_req_type'(REQ_BITS'($urandom));
      r.kind = kind;
      return r;
   endfunction

   task automatic send_req(matcher_req_type r, logic known, logic known_match);
      int gap;
      logic predicted;
      bit has_result;
      gap = 0;
      if ($urandom_range(0, 99) < source_idle_pct) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.kind <= r.kind;
      req_if.token_index <= r.slot;
      req_if.token_char <= r.tok;
      req_if.token_starred <= r.star;
      req_if.text_char <= r.txt;
      do @(posedge clock); while (!req_if.ready);
      has_result = advance_nfa(r, predicted);
      if (has_result) expected_matches.push_back(known ? known_match : predicted);
      if (r.kind != KIND_IGNORED) items_sent++;
   endtask

   // only with the matcher drained, incl. text transactions still in the pipe
   task automatic write_count(count_type v);
      req_if.valid <= 1'b0;
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.pattern_tokens <= v;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      count_shadow = v;
   endtask

   task automatic run_phase(bit burst);
      count_type cnt;
      int slots;
      int strings;
      int reps;
      int pick;
      bit hang;
      char_type text_buf [$];
      matcher_req_type r;
      pick = $urandom_range(0, 19);
      if (burst) cnt = count_type'($urandom_range(1, 3));
      else if (pick == 0) cnt = '0;
      else if (pick == 1) cnt = count_type'(MAX_TOKENS);
      else if (pick == 2) cnt = count_type'($urandom_range(MAX_TOKENS + 1, 63));
      else cnt = count_type'($urandom_range(1, 6));
      write_count(cnt);
      slots = (cnt > MAX_TOKENS) ? MAX_TOKENS : int'(cnt);
      for (int i = 0; i < slots; i++) begin
         r = random_req(KIND_LOAD);
         r.slot = INDEX_WIDTH'(i);
         r.tok = pattern_char();
         send_req(r, 1'b0, 1'b0);
      end
      if (!burst && $urandom_range(0, 3) == 0) begin
         r = random_req(KIND_LOAD);
         r.tok = pattern_char();
         send_req(r, 1'b0, 1'b0);
      end
      // receiver goes deaf while end-of-text transactions keep coming
      if (burst) hold_requests <= hold_requests + 1;
      strings = burst ? 8 : $urandom_range(2, 5);
      for (int s = 0; s < strings; s++) begin
         text_buf.delete();
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(0, 4)) text_buf.push_back(char_type'($urandom));
         end else begin
            // walk the pattern so that most texts come close to matching
            for (int i = 0; i < slots; i++) begin
               reps = pat_star[i] ? $urandom_range(0, 3) : 1;
               repeat (reps)
                  text_buf.push_back((pat_char[i] == CH_DOT) ? char_type'($urandom)
                                                            : pat_char[i]);
            end
            if ($urandom_range(0, 2) == 0) begin
               pick = $urandom_range(0, text_buf.size());
               case ($urandom_range(0, 2))
                  0: text_buf.insert(pick, pattern_char());
                  1: if (pick < text_buf.size()) text_buf.delete(pick);
                  default: if (pick < text_buf.size()) text_buf[pick] = pattern_char();
               endcase
            end
         end
         foreach (text_buf[k]) begin
            if ($urandom_range(0, 19) == 0) send_req(random_req(KIND_IGNORED), 1'b0, 1'b0);
            if (!burst && slots > 0 && $urandom_range(0, 39) == 0) begin
               r = random_req(KIND_LOAD);
               r.slot = INDEX_WIDTH'($urandom_range(0, slots - 1));
               r.tok = pattern_char();
               send_req(r, 1'b0, 1'b0);
            end
            r = random_req(KIND_TEXT);
            r.txt = text_buf[k];
            send_req(r, 1'b0, 1'b0);
         end
         hang = !burst && (s == strings - 1) && ($urandom_range(0, 3) == 0);
         if (!hang) send_req(random_req(KIND_END), 1'b0, 1'b0);
      end
   endtask

   initial begin
      matcher_req_type r;
      int probe_items;
      int done;
      int phase_no;
      for (int i = 0; i < MAX_TOKENS; i++) begin
         pat_char[i] = '0;
         pat_star[i] = 1'b0;
      end
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.kind <= KIND_LOAD;
      req_if.token_index <= '0;
      req_if.token_char <= '0;
      req_if.token_starred <= 1'b0;
      req_if.text_char <= '0;
      csr_if.valid <= 1'b0;
      csr_if.pattern_tokens <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      source_idle_pct = 6;
      sink_idle_pct = 60;
      foreach (probe_table[k]) begin
         if (probe_table[k].op == ROW_COUNT) begin
            write_count(probe_table[k].count_val);
         end else begin
            r.kind = probe_table[k].kind;
            r.slot = probe_table[k].slot;
            r.tok = probe_table[k].tok;
            r.star = probe_table[k].star;
            r.txt = probe_table[k].txt;
            send_req(r, probe_table[k].known, probe_table[k].known_match);
         end
      end

      probe_items = items_sent;
      phase_no = 0;
      while (items_sent < probe_items + RANDOM_ITEMS) begin
         done = items_sent - probe_items;
         if (done < RANDOM_ITEMS / 3) begin
            source_idle_pct = 6;
            sink_idle_pct = 60;
         end else if (done < 2 * RANDOM_ITEMS / 3) begin
            source_idle_pct = 60;
            sink_idle_pct = 6;
         end else begin
            source_idle_pct = 0;
            sink_idle_pct = 0;
         end
         run_phase(phase_no == 1);
         phase_no++;
      end

      req_if.valid <= 1'b0;
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fails == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      int hold_left;
      int holds_seen;
      hold_left = 0;
      holds_seen = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      logic want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_matches.size() == 0) begin
            $error("matched: no transaction expected, got %0b", rsp_if.matched);
            fails++;
         end else begin
            want = expected_matches.pop_front();
            if (rsp_if.matched !== want) begin
               $error("matched: expected %0b, got %0b", want, rsp_if.matched);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
